FILE: rtl/hamming_checked_frame_receiver_core_assert.svh
// -----------------------------------------------------------------------------
// Frame receiver assertion macros
// Short forms for the checks at the end of the receiver top level.
// -----------------------------------------------------------------------------
`ifndef HAMMING_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH
`define HAMMING_CHECKED_FRAME_RECEIVER_CORE_ASSERT_SVH

// Condition in this cycle implies consequence in the same cycle.
`define HCFR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Condition in this cycle implies consequence in the next cycle.
`define HCFR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/hcfr_pkg.sv
// -----------------------------------------------------------------------------
// Frame receiver package
// Sizes, marker codes, result codes and the Hamming encoder.
// -----------------------------------------------------------------------------
`default_nettype none

package hcfr_pkg;

   localparam int STACK_DEPTH      = 32;
   localparam int REASSEMBLY_DEPTH = 64;

   localparam int ID_W     = 6;
   localparam int BYTE_W   = 8;
   localparam int CHECK_W  = 12;
   localparam int STATUS_W = 4;

   localparam int STACK_AW = $clog2(STACK_DEPTH);
   localparam int STACK_CW = $clog2(STACK_DEPTH + 1);
   localparam int ASM_AW   = $clog2(REASSEMBLY_DEPTH);
   localparam int ASM_CW   = $clog2(REASSEMBLY_DEPTH + 1);

   localparam logic [CHECK_W-1:0] MARK_START = CHECK_W'(60);
   localparam logic [CHECK_W-1:0] MARK_END   = CHECK_W'(195);
   localparam logic [CHECK_W-1:0] MARK_ACK   = CHECK_W'(127);

   typedef enum logic [STATUS_W-1:0] {
      ST_STARTED  = 4'd0,
      ST_ACCEPTED = 4'd1,
      ST_FULL     = 4'd2,
      ST_DUP      = 4'd3,
      ST_ACKMIS   = 4'd4,
      ST_CHECK    = 4'd5,
      ST_STORED   = 4'd6,
      ST_DROPPED  = 4'd7,
      ST_IDLE     = 4'd8,
      ST_BYTE     = 4'd9,
      ST_EMPTY    = 4'd10
   } status_type;

   // Decoded view of one incoming frame word.
   typedef struct packed {
      logic is_start;
      logic is_end;
      logic is_ack_shape;
      logic code_ok;
   } frame_kind_type;

   // Parity at bits 0,1,3,7; data bits at 2,4,5,6,8,9,10,11.
   function automatic logic [CHECK_W-1:0] hamming_code(input logic [BYTE_W-1:0] b);
      logic p1;
      logic p2;
      logic p4;
      logic p8;
      p1 = b[0] ^ b[1] ^ b[3] ^ b[4] ^ b[6];
      p2 = b[0] ^ b[2] ^ b[3] ^ b[5] ^ b[6];
      p4 = b[1] ^ b[2] ^ b[3] ^ b[7];
      p8 = b[4] ^ b[5] ^ b[6] ^ b[7];
      return {b[7], b[6], b[5], b[4], p8, b[3], b[2], b[1], p4, b[0], p2, p1};
   endfunction

endpackage

`default_nettype wire

FILE: rtl/hcfr_ram.sv
// -----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port, one read port, read data registered.
// -----------------------------------------------------------------------------
`default_nettype none

module hcfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: rtl/hcfr_classify.sv
// -----------------------------------------------------------------------------
// Frame classifier
// Decode markers and the ack shape, and check the Hamming code word.
// -----------------------------------------------------------------------------
`default_nettype none

module hcfr_classify (
   input  wire logic [hcfr_pkg::ID_W-1:0]    frame_id,
   input  wire logic [hcfr_pkg::BYTE_W-1:0]  frame_byte,
   input  wire logic [hcfr_pkg::CHECK_W-1:0] frame_check,
   output hcfr_pkg::frame_kind_type          kind
);

   import hcfr_pkg::*;

   logic id_zero;
   logic marker_shape;

   assign id_zero      = (frame_id == '0);
   assign marker_shape = id_zero && (frame_byte == '0);

   assign kind.is_start     = marker_shape && (frame_check == MARK_START);
   assign kind.is_end       = marker_shape && (frame_check == MARK_END);
   assign kind.is_ack_shape = id_zero && (frame_check == MARK_ACK);
   assign kind.code_ok      = (hamming_code(frame_byte) == frame_check);

endmodule

`default_nettype wire

FILE: rtl/hamming_checked_frame_receiver_core.sv
// -----------------------------------------------------------------------------
// Hamming-checked frame receiver core
// Checks incoming frames, holds accepted ones on a LIFO stack, pops them on
// drain ticks into an in-order reassembly buffer and delivers it on request.
// -----------------------------------------------------------------------------
//
//   channel   ports                               handshake
//   -------   ---------------------------------   ------------------------------
//   request   req_op, req_frame_id/_byte/_check   taken when start && !busy
//   response  rsp_status, rsp_ack_id,             one cycle per word, marked by
//             rsp_out_byte, rsp_last              rsp_valid, never held off
//
// Start markers, end markers on an empty buffer, full-stack rejects and ticks
// on an empty stack answer the cycle after the word is taken. A data frame
// first runs the duplicate-id scan (one stack-memory read per cycle). A tick
// answers from POP with the registered stack read. An end marker streams one
// byte word per cycle out of the reassembly memory behind a registered read.
// Reset is synchronous; it clears counts and the sequencer, not the memories.
// The receiver cannot stall, so every word on the response port is final.
// -----------------------------------------------------------------------------
`default_nettype none

`include "hamming_checked_frame_receiver_core_assert.svh"

module hamming_checked_frame_receiver_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic                          req_op,
   input  wire logic [hcfr_pkg::ID_W-1:0]     req_frame_id,
   input  wire logic [hcfr_pkg::BYTE_W-1:0]   req_frame_byte,
   input  wire logic [hcfr_pkg::CHECK_W-1:0]  req_frame_check,
   output logic                               rsp_valid,
   output logic      [hcfr_pkg::STATUS_W-1:0] rsp_status,
   output logic      [hcfr_pkg::ID_W-1:0]     rsp_ack_id,
   output logic      [hcfr_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                               rsp_last
);

   import hcfr_pkg::*;

   // IDLE: wait for a word. SCAN: walk held ids one per cycle.
   // POP: stack read data arrives. DRAIN: stream the reassembly buffer.
   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_POP,
      S_DRAIN
   } state_type;

   // Sequencer and counters
   state_type             state_ff,         state_in;
   logic [STACK_CW-1:0]   held_count_ff,    held_count_in;
   logic [STACK_AW-1:0]   scan_idx_ff,      scan_idx_in;
   logic [ID_W-1:0]       first_index_ff,   first_index_in;
   logic [ID_W-1:0]       last_index_ff,    last_index_in;
   logic [ASM_CW-1:0]     asm_count_ff,     asm_count_in;

   // Captured request word (payload, no reset)
   logic [ID_W-1:0]       frame_id_ff;
   logic [BYTE_W-1:0]     frame_byte_ff;
   logic [CHECK_W-1:0]    frame_check_ff;

   // Registered response word
   logic                  rsp_valid_ff,     rsp_valid_in;
   status_type            rsp_status_ff,    rsp_status_in;
   logic [ID_W-1:0]       rsp_ack_id_ff,    rsp_ack_id_in;
   logic [BYTE_W-1:0]     rsp_out_byte_ff,  rsp_out_byte_in;
   logic                  rsp_last_ff,      rsp_last_in;

   // Frame under check: live request in IDLE, captured copy afterwards
   logic [ID_W-1:0]       cur_id;
   logic [BYTE_W-1:0]     cur_byte;
   logic [CHECK_W-1:0]    cur_check;
   frame_kind_type        cur_kind;
   status_type            frame_verdict;

   logic                  accept;

   // Stack memory: {id, byte} per held frame
   logic                     stk_wr_en;
   logic [STACK_AW-1:0]      stk_wr_addr;
   logic [ID_W+BYTE_W-1:0]   stk_wr_data;
   logic [STACK_AW-1:0]      stk_rd_addr;
   logic [ID_W+BYTE_W-1:0]   stk_rd_data;
   logic [ID_W-1:0]          pop_id;
   logic [BYTE_W-1:0]        pop_byte;

   // Reassembly memory, indexed by frame id
   logic                     asm_wr_en;
   logic [ASM_AW-1:0]        asm_wr_addr;
   logic [BYTE_W-1:0]        asm_wr_data;
   logic [ASM_AW-1:0]        asm_rd_addr;
   logic [BYTE_W-1:0]        asm_rd_data;

   logic [STACK_CW-1:0]      held_dec;
   logic [STACK_CW-1:0]      scan_pos;
   logic [ID_W-1:0]          first_next;
   logic                     pop_in_range;
   logic                     pop_follows;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   assign cur_id    = (state_ff == S_IDLE) ? req_frame_id    : frame_id_ff;
   assign cur_byte  = (state_ff == S_IDLE) ? req_frame_byte  : frame_byte_ff;
   assign cur_check = (state_ff == S_IDLE) ? req_frame_check : frame_check_ff;

   hcfr_classify u_classify (
      .frame_id    (cur_id),
      .frame_byte  (cur_byte),
      .frame_check (cur_check),
      .kind        (cur_kind)
   );

   // Checks after the duplicate scan, in priority order.
   assign frame_verdict = cur_kind.is_ack_shape ? ST_ACKMIS :
                          !cur_kind.code_ok     ? ST_CHECK  : ST_ACCEPTED;

   hcfr_ram #(
      .WIDTH (ID_W + BYTE_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack_ram (
      .clock   (clock),
      .wr_en   (stk_wr_en),
      .wr_addr (stk_wr_addr),
      .wr_data (stk_wr_data),
      .rd_addr (stk_rd_addr),
      .rd_data (stk_rd_data)
   );

   hcfr_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (REASSEMBLY_DEPTH)
   ) u_asm_ram (
      .clock   (clock),
      .wr_en   (asm_wr_en),
      .wr_addr (asm_wr_addr),
      .wr_data (asm_wr_data),
      .rd_addr (asm_rd_addr),
      .rd_data (asm_rd_data)
   );

   assign pop_id   = stk_rd_data[ID_W+BYTE_W-1:BYTE_W];
   assign pop_byte = stk_rd_data[BYTE_W-1:0];

   assign held_dec   = held_count_ff - STACK_CW'(1);
   assign scan_pos   = STACK_CW'(scan_idx_ff) + STACK_CW'(1);
   assign first_next = first_index_ff + ID_W'(1);

   // Store only ids inside the buffer that start a run or extend it by one.
   assign pop_in_range = ((ID_W+1)'(pop_id) < (ID_W+1)'(REASSEMBLY_DEPTH));
   assign pop_follows  = ((ID_W+1)'(pop_id) == ((ID_W+1)'(last_index_ff) + (ID_W+1)'(1)));

   assign stk_wr_addr = held_count_ff[STACK_AW-1:0];
   assign stk_wr_data = {cur_id, cur_byte};
   assign asm_wr_addr = pop_id[ASM_AW-1:0];
   assign asm_wr_data = pop_byte;

   always_comb begin
      state_in        = state_ff;
      held_count_in   = held_count_ff;
      scan_idx_in     = scan_idx_ff;
      first_index_in  = first_index_ff;
      last_index_in   = last_index_ff;
      asm_count_in    = asm_count_ff;
      rsp_valid_in    = 1'b0;
      rsp_status_in   = ST_IDLE;
      rsp_ack_id_in   = '0;
      rsp_out_byte_in = '0;
      rsp_last_in     = 1'b1;
      stk_wr_en       = 1'b0;
      stk_rd_addr     = '0;
      asm_wr_en       = 1'b0;
      asm_rd_addr     = first_index_ff[ASM_AW-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (req_op) begin
                  // Tick: pop the top frame, or report idle on an empty stack.
                  if (held_count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_IDLE;
                  end else begin
                     held_count_in = held_dec;
                     stk_rd_addr   = held_dec[STACK_AW-1:0];
                     state_in      = S_POP;
                  end
               end else if (cur_kind.is_start) begin
                  held_count_in  = '0;
                  first_index_in = '0;
                  last_index_in  = '0;
                  asm_count_in   = '0;
                  rsp_valid_in   = 1'b1;
                  rsp_status_in  = ST_STARTED;
               end else if (cur_kind.is_end) begin
                  if (asm_count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_status_in = ST_EMPTY;
                  end else begin
                     // Read of the oldest byte is already under way.
                     state_in = S_DRAIN;
                  end
               end else if (held_count_ff >= STACK_CW'(STACK_DEPTH)) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = ST_FULL;
               end else if (held_count_ff == '0) begin
                  // Nothing to scan: decide now.
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = frame_verdict;
                  if (frame_verdict == ST_ACCEPTED) begin
                     stk_wr_en     = 1'b1;
                     held_count_in = held_count_ff + STACK_CW'(1);
                  end
               end else begin
                  scan_idx_in = '0;
                  stk_rd_addr = '0;
                  state_in    = S_SCAN;
               end
            end
         end

         S_SCAN: begin
            if (pop_id == frame_id_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = ST_DUP;
               state_in      = S_IDLE;
            end else if (scan_pos == held_count_ff) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = frame_verdict;
               state_in      = S_IDLE;
               if (frame_verdict == ST_ACCEPTED) begin
                  stk_wr_en     = 1'b1;
                  held_count_in = held_count_ff + STACK_CW'(1);
               end
            end else begin
               // Advance to the next held entry.
               scan_idx_in = scan_idx_ff + STACK_AW'(1);
               stk_rd_addr = scan_idx_ff + STACK_AW'(1);
            end
         end

         S_POP: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
            if (pop_id == '0) begin
               rsp_status_in = ST_IDLE;
            end else if (pop_in_range && ((asm_count_ff == '0) || pop_follows)) begin
               asm_wr_en     = 1'b1;
               last_index_in = pop_id;
               asm_count_in  = asm_count_ff + ASM_CW'(1);
               if (asm_count_ff == '0) begin
                  first_index_in = pop_id;
               end
               rsp_status_in = ST_STORED;
               rsp_ack_id_in = pop_id;
            end else begin
               rsp_status_in = ST_DROPPED;
               rsp_ack_id_in = pop_id;
            end
         end

         S_DRAIN: begin
            // Emit one byte per cycle and keep the next read one step ahead.
            rsp_valid_in    = 1'b1;
            rsp_status_in   = ST_BYTE;
            rsp_out_byte_in = asm_rd_data;
            rsp_last_in     = (asm_count_ff == ASM_CW'(1));
            first_index_in  = first_next;
            asm_count_in    = asm_count_ff - ASM_CW'(1);
            asm_rd_addr     = first_next[ASM_AW-1:0];
            if (asm_count_ff == ASM_CW'(1)) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_IDLE;
         held_count_ff  <= '0;
         scan_idx_ff    <= '0;
         first_index_ff <= '0;
         last_index_ff  <= '0;
         asm_count_ff   <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         held_count_ff  <= held_count_in;
         scan_idx_ff    <= scan_idx_in;
         first_index_ff <= first_index_in;
         last_index_ff  <= last_index_in;
         asm_count_ff   <= asm_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rsp_status_ff   <= rsp_status_in;
      rsp_ack_id_ff   <= rsp_ack_id_in;
      rsp_out_byte_ff <= rsp_out_byte_in;
      rsp_last_ff     <= rsp_last_in;
      if (accept) begin
         frame_id_ff    <= req_frame_id;
         frame_byte_ff  <= req_frame_byte;
         frame_check_ff <= req_frame_check;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_status   = rsp_status_ff;
   assign rsp_ack_id   = rsp_ack_id_ff;
   assign rsp_out_byte = rsp_out_byte_ff;
   assign rsp_last     = rsp_last_ff;

   // Hold the stack count within the memory depth.
   `HCFR_ASSERT_SAME(a_held_bound, clock, reset, 1'b1,
      held_count_ff <= STACK_CW'(STACK_DEPTH), "held count beyond stack depth")

   // Drain only while bytes remain, and every drain cycle emits a word.
   `HCFR_ASSERT_SAME(a_drain_nonempty, clock, reset, state_ff == S_DRAIN,
      asm_count_ff != '0, "drain with empty reassembly")
   `HCFR_ASSERT_NEXT(a_drain_emits, clock, reset, state_ff == S_DRAIN,
      rsp_valid, "drain cycle without a response word")

   // The last word of an item shows exactly when the receiver is free again.
   `HCFR_ASSERT_SAME(a_last_frees, clock, reset, rsp_valid,
      rsp_last == !busy, "last flag out of step with busy")

endmodule

`default_nettype wire

FILE: verif/testbench.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Frame receiver core testbench
// Feeds frame and drain-tick words to the receiver: directed cases, a stack
// fill that overflows and drains into a 63-byte run, and random runs mixed
// with noise. Results are predicted word by word and compared in order.
// -----------------------------------------------------------------------------

module testbench;

   import hcfr_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int FEED_TARGET = 160;   // directed + long run + a few random words

   // One word queued for the request side.
   typedef struct {
      logic                op;
      logic [ID_W-1:0]     id;
      logic [BYTE_W-1:0]   data;
      logic [CHECK_W-1:0]  check;
      bit                  drain_first;   // hold until every result is in
   } frame_word_type;

   // One word expected on the response side.
   typedef struct {
      status_type          status;
      logic [ID_W-1:0]     ack;
      logic [BYTE_W-1:0]   data;
      logic                last;
   } frame_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic                req_op = 1'b0;
   logic [ID_W-1:0]     req_frame_id = '0;
   logic [BYTE_W-1:0]   req_frame_byte = '0;
   logic [CHECK_W-1:0]  req_frame_check = '0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_ack_id;
   logic [BYTE_W-1:0]   rsp_out_byte;
   logic                rsp_last;

   hamming_checked_frame_receiver_core uut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_op          (req_op),
      .req_frame_id    (req_frame_id),
      .req_frame_byte  (req_frame_byte),
      .req_frame_check (req_frame_check),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_ack_id      (rsp_ack_id),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last        (rsp_last)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   // ---------------------------------------------------------------------------
   // Receiver shadow: held-frame stack and in-order reassembly run
   // ---------------------------------------------------------------------------
   logic [ID_W-1:0]   held_id   [STACK_DEPTH];
   logic [BYTE_W-1:0] held_data [STACK_DEPTH];
   int                held_fill = 0;
   logic [BYTE_W-1:0] run_mem   [REASSEMBLY_DEPTH];
   logic [ID_W-1:0]   run_first = '0;
   logic [ID_W-1:0]   run_last  = '0;
   int                run_len   = 0;

   frame_word_type    feed[$];
   frame_result_type  due_words[$];

   bit                taken = 1'b0;     // a word was taken at the last rising edge
   int                words_sent = 0;
   int                words_taken = 0;
   int                ticks_taken = 0;
   int                results_seen = 0;
   int                byte_burst = 0;
   int                longest_burst = 0;
   int                mismatches = 0;
   int                cycle_count = 0;

   // Hamming(12,8): parity at bits 0,1,3,7, each over its own data-bit mask.
   function automatic logic [CHECK_W-1:0] code_of(input logic [BYTE_W-1:0] d);
      logic p1, p2, p4, p8;
      p1 = ^(d & 8'h5B);
      p2 = ^(d & 8'h6D);
      p4 = ^(d & 8'h8E);
      p8 = ^(d & 8'hF0);
      return {d[7:4], p8, d[3:1], p4, d[0], p2, p1};
   endfunction

   // Advance the shadow by one taken word and queue the results it causes.
   task automatic apply_frame_word(input logic op, input logic [ID_W-1:0] id,
         input logic [BYTE_W-1:0] data, input logic [CHECK_W-1:0] check);
      frame_result_type  r;
      logic [ID_W-1:0]   pid;
      logic [BYTE_W-1:0] pdata;
      bit                dup;
      int                i;
      r = '{ST_IDLE, '0, '0, 1'b1};
      if (op) begin
         // Pop the top frame; an empty stack or a popped id 0 reads as idle.
         if (held_fill != 0) begin
            held_fill--;
            pid   = held_id[held_fill];
            pdata = held_data[held_fill];
            if (pid != 0) begin
               r.ack = pid;
               if (pid < REASSEMBLY_DEPTH &&
                   (run_len == 0 || int'(pid) == int'(run_last) + 1)) begin
                  if (run_len == 0) run_first = pid;
                  run_last     = pid;
                  run_mem[pid] = pdata;
                  run_len++;
                  r.status = ST_STORED;
               end else begin
                  r.status = ST_DROPPED;
               end
            end
         end
         due_words.push_back(r);
      end else if (id == 0 && data == 0 && check == MARK_START) begin
         held_fill = 0;
         run_len   = 0;
         run_first = '0;
         run_last  = '0;
         r.status  = ST_STARTED;
         due_words.push_back(r);
      end else if (id == 0 && data == 0 && check == MARK_END) begin
         if (run_len == 0) begin
            r.status = ST_EMPTY;
            due_words.push_back(r);
         end
         // Stream the run oldest first, marking the final byte.
         while (run_len != 0) begin
            r.status = ST_BYTE;
            r.data   = run_mem[run_first];
            run_first++;
            run_len--;
            r.last   = (run_len == 0);
            due_words.push_back(r);
         end
      end else begin
         dup = 1'b0;
         for (i = 0; i < held_fill; i++)
            if (held_id[i] == id) dup = 1'b1;
         if (held_fill >= STACK_DEPTH)
            r.status = ST_FULL;
         else if (dup)
            r.status = ST_DUP;
         else if (id == 0 && check == MARK_ACK)
            r.status = ST_ACKMIS;
         else if (check != code_of(data))
            r.status = ST_CHECK;
         else begin
            held_id[held_fill]   = id;
            held_data[held_fill] = data;
            held_fill++;
            r.status = ST_ACCEPTED;
         end
         due_words.push_back(r);
      end
   endtask

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $time, what);
   endtask

   // Compare the word on the response port with the oldest expectation.
   task automatic check_result();
      frame_result_type w;
      results_seen++;
      if (rsp_status == ST_BYTE) byte_burst++;
      if (rsp_last === 1'b1) begin
         if (byte_burst > longest_burst) longest_burst = byte_burst;
         byte_burst = 0;
      end
      if (due_words.size() == 0) begin
         report_mismatch($sformatf("unexpected result word, status %0d", rsp_status));
      end else begin
         w = due_words.pop_front();
         if (rsp_status !== w.status)
            report_mismatch($sformatf("status %0d, want %s", rsp_status, w.status.name()));
         if (rsp_ack_id !== w.ack)
            report_mismatch($sformatf("ack_id %0d, want %0d", rsp_ack_id, w.ack));
         if (rsp_out_byte !== w.data)
            report_mismatch($sformatf("out_byte %02h, want %02h", rsp_out_byte, w.data));
         if (rsp_last !== w.last)
            report_mismatch($sformatf("last %b, want %b", rsp_last, w.last));
      end
   endtask

   // ---------------------------------------------------------------------------
   // Monitor: sample at the rising edge. Check the result first, since a word
   // taken at this edge cannot answer before the next cycle.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      taken <= !reset && start && busy === 1'b0;
      if (!reset) begin
         if (rsp_valid === 1'b1) check_result();
         if (start && busy === 1'b0) begin
            apply_frame_word(req_op, req_frame_id, req_frame_byte, req_frame_check);
            words_taken++;
            if (req_op) ticks_taken++;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Driver: change inputs at the falling edge. Hold a presented word until it
   // is taken; then present the next one or idle at random. Words 30..109
   // go out back to back.
   // ---------------------------------------------------------------------------
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!start || taken) begin
         if (feed.size() != 0 &&
             !(feed[0].drain_first && due_words.size() != 0) &&
             ((words_sent >= 30 && words_sent < 110) || $urandom_range(99) >= 35)) begin
            req_op          <= feed[0].op;
            req_frame_id    <= feed[0].id;
            req_frame_byte  <= feed[0].data;
            req_frame_check <= feed[0].check;
            start           <= 1'b1;
            void'(feed.pop_front());
            words_sent++;
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d words still queued", cycle_count,
                  feed.size());
         $display("CHECK FAILED");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------
   task automatic add_word(input logic op, input logic [ID_W-1:0] id,
         input logic [BYTE_W-1:0] data, input logic [CHECK_W-1:0] check, input bit drain);
      frame_word_type w;
      w = '{op, id, data, check, drain};
      feed.push_back(w);
   endtask

   task automatic add_frame(input logic [ID_W-1:0] id, input logic [BYTE_W-1:0] data);
      add_word(1'b0, id, data, code_of(data), 1'b0);
   endtask

   task automatic add_tick();
      add_word(1'b1, ID_W'($urandom), BYTE_W'($urandom), CHECK_W'($urandom), 1'b0);
   endtask

   task automatic add_marker(input logic [CHECK_W-1:0] mark, input bit drain);
      add_word(1'b0, '0, '0, mark, drain);
   endtask

   initial begin : stimulus
      int n, base, k, pick, r;
      logic [BYTE_W-1:0] d;

      // Directed: empty-state answers, every reject but a full stack, id 0 on the
      // stack, a drop, an in-order run and its delivery.
      add_tick();                                    // tick on empty stack
      add_marker(MARK_END, 1'b0);                    // end with nothing assembled
      add_marker(MARK_START, 1'b0);
      add_frame(6'd1, 8'h00);
      add_frame(6'd1, 8'h33);                        // duplicate id
      add_word(1'b0, 6'd0, 8'hFF, MARK_ACK, 1'b0);   // ack shape
      add_word(1'b0, 6'd2, 8'hFF, code_of(8'hFF) ^ 12'h800, 1'b0);   // bad code
      add_frame(6'd2, 8'hFF);
      add_frame(6'd0, 8'h00);                        // id 0 data frame, code 0
      add_frame(6'd63, 8'h80);
      add_tick();                                    // 63 starts the run
      add_tick();                                    // id 0 pops as idle
      add_tick();                                    // 2 does not follow 63
      add_tick();
      add_marker(MARK_END, 1'b0);
      add_frame(6'd3, 8'hC3);
      add_frame(6'd2, 8'h5A);
      add_frame(6'd1, 8'hA5);
      repeat (3) add_tick();
      add_word(1'b0, 6'd0, 8'h00, MARK_ACK, 1'b0);
      add_marker(MARK_END, 1'b1);
      add_tick();
      add_marker(MARK_START, 1'b0);

      // Fill the stack, overflow it, and drain two halves into a 63-byte run.
      add_marker(MARK_START, 1'b0);
      for (k = 32; k >= 1; k--) add_frame(ID_W'(k), BYTE_W'($urandom));
      add_frame(ID_W'($urandom_range(33, 63)), BYTE_W'($urandom));
      repeat (32) add_tick();
      for (k = 63; k >= 33; k--) add_frame(ID_W'(k), BYTE_W'($urandom));
      repeat (31) add_tick();
      add_marker(MARK_END, 1'b1);

      // Random: mostly well-formed runs with random content, plus noise.
      while (feed.size() < FEED_TARGET) begin
         pick = $urandom_range(99);
         if (pick < 65) begin
            if ($urandom_range(1)) add_marker(MARK_START, 1'b0);
            n    = $urandom_range(1, 6);
            base = $urandom_range(1, 64 - n);
            for (k = n - 1; k >= 0; k--) begin
               d = BYTE_W'($urandom);
               r = $urandom_range(9);
               if (r == 0)
                  add_word(1'b0, ID_W'(base + k), d,
                           code_of(d) ^ CHECK_W'(1 << $urandom_range(11)), 1'b0);
               else if (r == 1)
                  add_frame(ID_W'(base + n - 1), d);
               else
                  add_frame(ID_W'(base + k), d);
            end
            repeat (n + $urandom_range(1)) add_tick();
            if ($urandom_range(9) < 7) add_marker(MARK_END, 1'b0);
         end else if (pick < 85) begin
            d = BYTE_W'($urandom);
            add_word(1'($urandom), ID_W'($urandom), d,
                     $urandom_range(3) == 0 ? code_of(d) : CHECK_W'($urandom_range(4095)),
                     1'b0);
         end else begin
            case ($urandom_range(3))
               0: add_marker(MARK_START, 1'b0);
               1: add_marker(MARK_END, 1'b0);
               2: add_word(1'b0, '0, BYTE_W'($urandom), MARK_ACK, 1'b0);
               default: add_tick();
            endcase
         end
      end

      // Hold reset, then release it on a falling edge.
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Wait for the feed to drain and every result to arrive, then settle.
      while (feed.size() != 0 || start || due_words.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);

      $display("covered %0d words (%0d drain ticks), %0d result words checked",
               words_taken, ticks_taken, results_seen);
      $display("longest delivered byte burst %0d, mismatches %0d",
               longest_burst, mismatches);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
